>>> rtl/spbn_pkg.sv
package spbn_pkg;

  localparam int OP_W       = 2;
  localparam int SCALED_W   = 16;
  localparam int BAND_W     = 3;
  localparam int EDGE_W     = 16;
  localparam int EDGE_SLOTS = 8;
  localparam int FSTEP_W    = 16;
  localparam int ECNT_W     = 4;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_W     = 8;

  localparam logic [FSTEP_W-1:0]  FREQ_STEP_RST  = 16'd256;
  localparam logic [ECNT_W-1:0]   EDGE_COUNT_RST = 4'd8;
  localparam logic [SCALED_W-1:0] SCALED_MAX     = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_OBSERVE    = 2'd0,
    OP_SCALE      = 2'd1,
    OP_BAND_SCALE = 2'd2,
    OP_CLEAR      = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_STEP  = 2'd0,
    CFG_EDGE_COUNT = 2'd1,
    CFG_EDGES_LOW  = 2'd2,
    CFG_EDGES_HIGH = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MATCH,
    ST_PREP,
    ST_CHK,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

>>> rtl/spbn_in_if.sv
interface spbn_in_if #(
  parameter int MAG_BITS   = 24,
  parameter int INDEX_BITS = 12
);
  logic                          valid;
  logic                          ready;
  logic [spbn_pkg::OP_W-1:0]     operation;
  logic [INDEX_BITS-1:0]         bin_idx;
  logic [MAG_BITS-1:0]           magnitude;

  modport source (output valid, operation, bin_idx, magnitude, input ready);
  modport sink   (input valid, operation, bin_idx, magnitude, output ready);
endinterface

>>> rtl/spbn_out_if.sv
interface spbn_out_if;
  logic                            valid;
  logic                            ready;
  logic [spbn_pkg::SCALED_W-1:0]   scaled;
  logic                            in_band;
  logic [spbn_pkg::BAND_W-1:0]     band;
  logic                            divide_by_zero;

  modport source (output valid, scaled, in_band, band, divide_by_zero, input ready);
  modport sink   (input valid, scaled, in_band, band, divide_by_zero, output ready);
endinterface

>>> rtl/spectrum_band_peak_normalizer.sv
// Channel   | Dir | Payload                                   | Beat
// ----------+-----+-------------------------------------------+------------------------
// in_i      | in  | operation, bin_idx, magnitude             | valid & ready
// out_o     | out | scaled, in_band, band, divide_by_zero     | valid & ready
// cfg       | in  | cfg_idx_i, cfg_wdata_i                    | cfg_we_i
//
// One item at a time: an accept step (all a clear needs), a bit-serial multiply over the
// INDEX_BITS index bits, band compares until one matches or the bands run out, and an update
// step. A scale adds a check, a bit-serial division (skipped for a zero divisor or a
// saturating quotient) and an output load.
// A stalled sink holds the block in its final load; no input is taken meanwhile.
// Reset (async, active low) restores the config defaults and zeroes all peaks.
module spectrum_band_peak_normalizer #(
  parameter int NUM_EDGES  = 8,
  parameter int MAG_BITS   = 24,
  parameter int INDEX_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  spbn_in_if.sink                               in_i,
  spbn_out_if.source                            out_o,
  input  logic                                  cfg_we_i,
  input  logic [spbn_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [spbn_pkg::CFG_W-1:0]            cfg_wdata_i
);

  localparam int NUM_BANDS = NUM_EDGES - 1;
  localparam int BI_W      = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
  localparam int FREQ_W    = INDEX_BITS + spbn_pkg::FSTEP_W;
  localparam int EDGE_Q_W  = spbn_pkg::EDGE_W + spbn_pkg::FRAC_W;
  localparam int CMP_W     = (FREQ_W > EDGE_Q_W) ? FREQ_W : EDGE_Q_W;
  localparam int STEP_MAX  = (INDEX_BITS > spbn_pkg::SCALED_W) ? INDEX_BITS
                                                                : spbn_pkg::SCALED_W;
  localparam int CNT_W     = $clog2(STEP_MAX);
  localparam int M100_W    = MAG_BITS + 7;
  localparam int NUM_W     = M100_W + spbn_pkg::FRAC_W;
  localparam int SW        = spbn_pkg::SCALED_W;

  // configuration
  logic [spbn_pkg::FSTEP_W-1:0] freq_step_q;
  logic [spbn_pkg::ECNT_W-1:0]  edge_count_q;
  logic [spbn_pkg::CFG_W-1:0]   edges_low_q, edges_high_q;

  // peaks
  logic [MAG_BITS-1:0] band_peak_q [NUM_BANDS];
  logic [MAG_BITS-1:0] overall_peak_q;

  // control
  spbn_pkg::state_e state_q, state_d;
  spbn_pkg::op_e    op_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_vld_q;
  logic             in_rdy;
  logic             out_load;
  logic             in_acc;

  // datapath
  logic [MAG_BITS-1:0]           mag_q;
  logic [INDEX_BITS-1:0]         idx_sh_q;
  logic [FREQ_W-1:0]             acc_q;
  logic [spbn_pkg::BAND_W-1:0]   band_q;
  logic                          hit_q;
  logic                          use_band_q;
  logic [MAG_BITS-1:0]           div_q;
  logic [MAG_BITS-1:0]           rem_q;
  logic [SW-1:0]                 q_q;
  logic                          dz_q;

  // output register
  logic [SW-1:0]                 out_scaled_q;
  logic                          out_in_band_q;
  logic [spbn_pkg::BAND_W-1:0]   out_band_q;
  logic                          out_dz_q;

  // band match
  logic [2*spbn_pkg::CFG_W-1:0]  edges_all;
  logic [spbn_pkg::ECNT_W-1:0]   ec_eff;
  logic [spbn_pkg::ECNT_W-1:0]   band_nx;
  logic                          band_ok;
  logic [spbn_pkg::EDGE_W-1:0]   lo_edge, hi_edge;
  logic [CMP_W-1:0]              freq_ext, lo_ext, hi_ext;
  logic                          in_range;

  // arithmetic
  logic [FREQ_W-1:0]             acc_add;
  logic [M100_W-1:0]             mag100;
  logic [NUM_W-1:0]              num;
  logic [MAG_BITS-1:0]           band_pk_sel;
  logic [MAG_BITS:0]             div_sh;
  logic [MAG_BITS:0]             div_diff;
  logic                          div_geq;

  assign in_acc = in_i.valid & in_rdy;

  assign edges_all = {edges_high_q, edges_low_q};
  assign ec_eff    = (edge_count_q > spbn_pkg::ECNT_W'(NUM_EDGES))
                     ? spbn_pkg::ECNT_W'(NUM_EDGES) : edge_count_q;
  assign band_nx   = {1'b0, band_q} + spbn_pkg::ECNT_W'(1);
  assign band_ok   = band_nx < ec_eff;
  assign lo_edge   = edges_all[band_q * spbn_pkg::EDGE_W +: spbn_pkg::EDGE_W];
  assign hi_edge   = edges_all[band_nx[spbn_pkg::BAND_W-1:0] * spbn_pkg::EDGE_W
                               +: spbn_pkg::EDGE_W];
  assign freq_ext  = CMP_W'(acc_q);
  assign lo_ext    = CMP_W'({lo_edge, {spbn_pkg::FRAC_W{1'b0}}});
  assign hi_ext    = CMP_W'({hi_edge, {spbn_pkg::FRAC_W{1'b0}}});
  assign in_range  = (lo_ext <= freq_ext) && (freq_ext <= hi_ext);

  // MSB-first shift-and-add, one index bit per cycle
  assign acc_add = {acc_q[FREQ_W-2:0], 1'b0}
                 + (idx_sh_q[INDEX_BITS-1] ? FREQ_W'(freq_step_q) : FREQ_W'(0));

  // magnitude * 100 = m*64 + m*32 + m*4, then FRAC_W fraction bits so the quotient is Q8.8
  assign mag100 = M100_W'({mag_q, 6'b0}) + M100_W'({mag_q, 5'b0})
                + M100_W'({mag_q, 2'b0});
  assign num    = {mag100, {spbn_pkg::FRAC_W{1'b0}}};

  assign band_pk_sel = band_peak_q[band_q[BI_W-1:0]];

  assign div_sh   = {rem_q, q_q[SW-1]};
  assign div_geq  = div_sh >= {1'b0, div_q};
  assign div_diff = div_sh - {1'b0, div_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spbn_pkg::ST_IDLE: begin
        if (in_acc && (in_i.operation != spbn_pkg::OP_CLEAR)) state_d = spbn_pkg::ST_MUL;
      end
      spbn_pkg::ST_MUL: begin
        if (cnt_q == '0) state_d = spbn_pkg::ST_MATCH;
      end
      spbn_pkg::ST_MATCH: begin
        if (!band_ok || in_range) state_d = spbn_pkg::ST_PREP;
      end
      spbn_pkg::ST_PREP: begin
        state_d = (op_q == spbn_pkg::OP_OBSERVE) ? spbn_pkg::ST_IDLE : spbn_pkg::ST_CHK;
      end
      spbn_pkg::ST_CHK: begin
        if ((div_q == '0) || (rem_q >= div_q)) state_d = spbn_pkg::ST_DONE;
        else state_d = spbn_pkg::ST_DIV;
      end
      spbn_pkg::ST_DIV: begin
        if (cnt_q == '0) state_d = spbn_pkg::ST_DONE;
      end
      spbn_pkg::ST_DONE: begin
        if (out_load) state_d = spbn_pkg::ST_IDLE;
      end
      default: state_d = spbn_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_rdy   = (state_q == spbn_pkg::ST_IDLE);
    out_load = (state_q == spbn_pkg::ST_DONE) && (!out_vld_q || out_o.ready);
  end

  assign in_i.ready           = in_rdy;
  assign out_o.valid          = out_vld_q;
  assign out_o.scaled         = out_scaled_q;
  assign out_o.in_band        = out_in_band_q;
  assign out_o.band           = out_band_q;
  assign out_o.divide_by_zero = out_dz_q;

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= spbn_pkg::ST_IDLE;
      out_vld_q      <= 1'b0;
      freq_step_q    <= spbn_pkg::FREQ_STEP_RST;
      edge_count_q   <= spbn_pkg::EDGE_COUNT_RST;
      edges_low_q    <= '0;
      edges_high_q   <= '0;
      overall_peak_q <= '0;
      for (int i = 0; i < NUM_BANDS; i++) band_peak_q[i] <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_load | (out_vld_q & ~out_o.ready);

      if (cfg_we_i) begin
        unique case (spbn_pkg::cfg_idx_e'(cfg_idx_i))
          spbn_pkg::CFG_FREQ_STEP:  freq_step_q  <= cfg_wdata_i[spbn_pkg::FSTEP_W-1:0];
          spbn_pkg::CFG_EDGE_COUNT: edge_count_q <= cfg_wdata_i[spbn_pkg::ECNT_W-1:0];
          spbn_pkg::CFG_EDGES_LOW:  edges_low_q  <= cfg_wdata_i;
          spbn_pkg::CFG_EDGES_HIGH: edges_high_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (in_acc && (in_i.operation == spbn_pkg::OP_CLEAR)) begin
        for (int i = 0; i < NUM_BANDS; i++) band_peak_q[i] <= '0;
      end

      if ((state_q == spbn_pkg::ST_PREP) && (op_q == spbn_pkg::OP_OBSERVE)) begin
        if (hit_q && (mag_q > band_pk_sel)) band_peak_q[band_q[BI_W-1:0]] <= mag_q;
        if (mag_q > overall_peak_q) overall_peak_q <= mag_q;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      spbn_pkg::ST_IDLE: begin
        op_q     <= spbn_pkg::op_e'(in_i.operation);
        mag_q    <= in_i.magnitude;
        idx_sh_q <= in_i.bin_idx;
        acc_q    <= '0;
        cnt_q    <= CNT_W'(INDEX_BITS - 1);
        band_q   <= '0;
        hit_q    <= 1'b0;
      end
      spbn_pkg::ST_MUL: begin
        acc_q    <= acc_add;
        idx_sh_q <= {idx_sh_q[INDEX_BITS-2:0], 1'b0};
        cnt_q    <= cnt_q - CNT_W'(1);
      end
      spbn_pkg::ST_MATCH: begin
        if (band_ok && in_range) hit_q <= 1'b1;
        else if (band_ok) band_q <= band_nx[spbn_pkg::BAND_W-1:0];
      end
      spbn_pkg::ST_PREP: begin
        use_band_q <= (op_q == spbn_pkg::OP_BAND_SCALE) && hit_q;
        div_q      <= ((op_q == spbn_pkg::OP_BAND_SCALE) && hit_q) ? band_pk_sel
                                                                  : overall_peak_q;
        // upper part of the numerator starts as the partial remainder
        rem_q      <= MAG_BITS'(num[NUM_W-1:SW]);
        q_q        <= num[SW-1:0];
        dz_q       <= 1'b0;
        cnt_q      <= CNT_W'(SW - 1);
      end
      spbn_pkg::ST_CHK: begin
        if (div_q == '0) begin
          q_q  <= use_band_q ? SW'(0) : spbn_pkg::SCALED_MAX;
          dz_q <= ~use_band_q;
        end else if (rem_q >= div_q) begin
          q_q  <= spbn_pkg::SCALED_MAX;   // quotient would not fit
        end
      end
      spbn_pkg::ST_DIV: begin
        rem_q <= div_geq ? div_diff[MAG_BITS-1:0] : div_sh[MAG_BITS-1:0];
        q_q   <= {q_q[SW-2:0], div_geq};
        cnt_q <= cnt_q - CNT_W'(1);
      end
      spbn_pkg::ST_DONE: ;
      default: ;
    endcase

    if (out_load) begin
      out_scaled_q  <= q_q;
      out_in_band_q <= hit_q;
      out_band_q    <= hit_q ? band_q : '0;
      out_dz_q      <= dz_q;
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int IDLE_CYCLES    = 64;
  localparam int LIMIT_CYCLES   = 600000;
  localparam int RAND_PHASES    = 14;
  localparam int PHASE_BEATS    = 100;
  localparam int DIR_RESET_ROWS = 4;
  localparam int DIR_ROWS       = 20;

  typedef struct packed {
    logic [spbn_pkg::SCALED_W-1:0] scaled;
    logic                          in_band;
    logic [spbn_pkg::BAND_W-1:0]   band;
    logic                          divide_by_zero;
  } result_t;

  typedef struct {
    spbn_pkg::op_e op;
    logic [11:0]   idx;
    logic [23:0]   mag;
    bit            typed;
    result_t       res;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [spbn_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [spbn_pkg::CFG_W-1:0]     cfg_wdata_i;

  spbn_in_if #(.MAG_BITS(24), .INDEX_BITS(12)) in_bus ();
  spbn_out_if out_bus ();

  spectrum_band_peak_normalizer #(
    .NUM_EDGES (8),
    .MAG_BITS  (24),
    .INDEX_BITS(12)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block: registers and peak store
  logic [spbn_pkg::FSTEP_W-1:0] cfg_step;
  logic [spbn_pkg::ECNT_W-1:0]  cfg_count;
  logic [63:0]                  cfg_lo;
  logic [63:0]                  cfg_hi;
  logic [23:0]                  band_pk [7];
  logic [23:0]                  overall_pk;

  result_t due_results [$];
  int      fail_count = 0;
  int      burst_left = 0;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // reset settings: every band is [0,0] Hz, no peaks yet
    '{spbn_pkg::OP_SCALE,      12'd5,    24'd100,    1'b1, '{16'hFFFF, 1'b0, 3'd0, 1'b1}},
    '{spbn_pkg::OP_BAND_SCALE, 12'd0,    24'd0,      1'b1, '{16'h0000, 1'b1, 3'd0, 1'b0}},
    '{spbn_pkg::OP_BAND_SCALE, 12'd4095, 24'hFFFFFF, 1'b1, '{16'hFFFF, 1'b0, 3'd0, 1'b1}},
    '{spbn_pkg::OP_SCALE,      12'd0,    24'd0,      1'b1, '{16'hFFFF, 1'b1, 3'd0, 1'b1}},
    // edges 0..500 Hz in steps of 100, then 650 and 600, so band 6 is inverted
    '{spbn_pkg::OP_OBSERVE,    12'd50,   24'd1000,   1'b0, NO_RES},
    '{spbn_pkg::OP_OBSERVE,    12'd150,  24'hFFFFFF, 1'b0, NO_RES},
    '{spbn_pkg::OP_BAND_SCALE, 12'd50,   24'd1000,   1'b0, NO_RES},
    '{spbn_pkg::OP_BAND_SCALE, 12'd100,  24'd500,    1'b0, NO_RES},
    '{spbn_pkg::OP_SCALE,      12'd150,  24'hFFFFFF, 1'b0, NO_RES},
    '{spbn_pkg::OP_BAND_SCALE, 12'd250,  24'd7,      1'b1, '{16'h0000, 1'b1, 3'd2, 1'b0}},
    '{spbn_pkg::OP_OBSERVE,    12'd620,  24'd1,      1'b0, NO_RES},
    '{spbn_pkg::OP_BAND_SCALE, 12'd620,  24'hFFFFFF, 1'b1, '{16'hFFFF, 1'b1, 3'd5, 1'b0}},
    '{spbn_pkg::OP_BAND_SCALE, 12'd4095, 24'd3,      1'b0, NO_RES},
    '{spbn_pkg::OP_OBSERVE,    12'd700,  24'd5,      1'b0, NO_RES},
    '{spbn_pkg::OP_BAND_SCALE, 12'd640,  24'd2,      1'b0, NO_RES},
    '{spbn_pkg::OP_CLEAR,      12'd0,    24'd0,      1'b0, NO_RES},
    '{spbn_pkg::OP_BAND_SCALE, 12'd150,  24'd9,      1'b1, '{16'h0000, 1'b1, 3'd1, 1'b0}},
    '{spbn_pkg::OP_SCALE,      12'd0,    24'd0,      1'b0, NO_RES},
    '{spbn_pkg::OP_OBSERVE,    12'd4095, 24'hFFFFFF, 1'b0, NO_RES},
    '{spbn_pkg::OP_SCALE,      12'd4095, 24'hFFFFFF, 1'b0, NO_RES}
  };

  function automatic logic [15:0] edge_hz(int i);
    return (i < 4) ? cfg_lo[16*i +: 16] : cfg_hi[16*(i-4) +: 16];
  endfunction

  // lowest band whose closed interval holds the frequency, -1 for none
  function automatic int band_hit(logic [27:0] freq_q8);
    int n;
    logic [23:0] lo;
    logic [23:0] hi;
    n = (cfg_count > 4'd8) ? 8 : int'(cfg_count);
    for (int b = 0; b + 1 < n; b++) begin
      lo = {edge_hz(b), 8'h00};
      hi = {edge_hz(b + 1), 8'h00};
      if (lo <= freq_q8 && freq_q8 <= hi) return b;
    end
    return -1;
  endfunction

  function automatic logic [15:0] pct_of_peak(logic [23:0] mag, logic [23:0] peak);
    longint unsigned q;
    q = (64'(mag) * 64'd25600) / 64'(peak);
    return (q > 64'd65535) ? spbn_pkg::SCALED_MAX : q[15:0];
  endfunction

  // advances the shadow state; returns 1 when the beat yields a result
  function automatic bit normalise_beat(spbn_pkg::op_e op, logic [11:0] idx,
                                        logic [23:0] mag, output result_t res);
    logic [27:0] freq_q8;
    int b;
    res = '0;
    if (op == spbn_pkg::OP_CLEAR) begin
      for (int i = 0; i < 7; i++) band_pk[i] = '0;
      return 1'b0;
    end
    freq_q8 = 28'(idx) * 28'(cfg_step);
    b = band_hit(freq_q8);
    if (op == spbn_pkg::OP_OBSERVE) begin
      if (b >= 0 && mag > band_pk[b]) band_pk[b] = mag;
      if (mag > overall_pk) overall_pk = mag;
      return 1'b0;
    end
    if (op == spbn_pkg::OP_BAND_SCALE && b >= 0) begin
      res.scaled = (band_pk[b] == '0) ? '0 : pct_of_peak(mag, band_pk[b]);
    end else if (overall_pk == '0) begin
      res.scaled         = spbn_pkg::SCALED_MAX;
      res.divide_by_zero = 1'b1;
    end else begin
      res.scaled = pct_of_peak(mag, overall_pk);
    end
    res.in_band = (b >= 0);
    res.band    = (b >= 0) ? 3'(b) : 3'd0;
    return 1'b1;
  endfunction

  task automatic send_beat(spbn_pkg::op_e op, logic [11:0] idx, logic [23:0] mag,
                           bit typed, result_t typed_res);
    result_t res;
    if (burst_left == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
    in_bus.valid     <= 1'b1;
    in_bus.operation <= op;
    in_bus.bin_idx   <= idx;
    in_bus.magnitude <= mag;
    do @(posedge clk_i); while (!in_bus.ready);
    if (normalise_beat(op, idx, mag, res)) due_results.push_back(typed ? typed_res : res);
    burst_left--;
  endtask

  // block is idle once all results are in and the last no-result beat has drained
  task automatic drain;
    in_bus.valid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic put_reg(spbn_pkg::cfg_idx_e idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_bands(logic [15:0] step, logic [3:0] count,
                            logic [63:0] lo, logic [63:0] hi);
    cfg_step  = step;
    cfg_count = count;
    cfg_lo    = lo;
    cfg_hi    = hi;
    put_reg(spbn_pkg::CFG_FREQ_STEP, 64'(step));
    put_reg(spbn_pkg::CFG_EDGE_COUNT, 64'(count));
    put_reg(spbn_pkg::CFG_EDGES_LOW, lo);
    put_reg(spbn_pkg::CFG_EDGES_HIGH, hi);
    cfg_we_i <= 1'b0;
  endtask

  // result side: check each beat, then pick the next ready level
  initial begin
    result_t exp_r;
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result beat: scaled %0d", out_bus.scaled);
          fail_count++;
        end else begin
          exp_r = due_results.pop_front();
          if (out_bus.scaled !== exp_r.scaled) begin
            $error("scaled: expected %0d, actual %0d", exp_r.scaled, out_bus.scaled);
            fail_count++;
          end
          if (out_bus.in_band !== exp_r.in_band) begin
            $error("in_band: expected %0d, actual %0d", exp_r.in_band, out_bus.in_band);
            fail_count++;
          end
          if (out_bus.band !== exp_r.band) begin
            $error("band: expected %0d, actual %0d", exp_r.band, out_bus.band);
            fail_count++;
          end
          if (out_bus.divide_by_zero !== exp_r.divide_by_zero) begin
            $error("divide_by_zero: expected %0d, actual %0d",
                   exp_r.divide_by_zero, out_bus.divide_by_zero);
            fail_count++;
          end
        end
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 200);
      end
      mode_left--;
      case (mode)
        0: out_bus.ready <= 1'b1;
        1: out_bus.ready <= 1'($urandom_range(0, 1));
        2: out_bus.ready <= ($urandom_range(0, 3) == 0);
        default: out_bus.ready <= (mode_left % 8 < 3);
      endcase
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("spectrum_band_peak_normalizer: mismatch");
    $finish;
  end

  initial begin
    logic [15:0]   step;
    logic [3:0]    count;
    logic [63:0]   lo;
    logic [63:0]   hi;
    logic [15:0]   edge_v [8];
    int unsigned   span;
    int unsigned   acc;
    int            r;
    spbn_pkg::op_e op;
    logic [23:0]   mag;

    in_bus.valid     = 1'b0;
    in_bus.operation = spbn_pkg::OP_OBSERVE;
    in_bus.bin_idx   = '0;
    in_bus.magnitude = '0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = spbn_pkg::CFG_FREQ_STEP;
    cfg_wdata_i      = '0;
    rst_ni           = 1'b0;
    cfg_step         = spbn_pkg::FREQ_STEP_RST;
    cfg_count        = spbn_pkg::EDGE_COUNT_RST;
    cfg_lo           = '0;
    cfg_hi           = '0;
    overall_pk       = '0;
    for (int i = 0; i < 7; i++) band_pk[i] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_RESET_ROWS) begin
        drain();
        load_bands(16'd256, 4'd8, {16'd300, 16'd200, 16'd100, 16'd0},
                   {16'd600, 16'd650, 16'd500, 16'd400});
      end
      send_beat(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].mag,
                dir_rows[i].typed, dir_rows[i].res);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      case ($urandom_range(0, 5))
        0:       step = 16'd0;
        1:       step = 16'hFFFF;
        2:       step = 16'd256;
        3:       step = 16'($urandom_range(0, 65535));
        default: step = 16'($urandom_range(32, 1024));
      endcase
      case ($urandom_range(0, 7))
        0:       count = 4'($urandom_range(0, 1));
        1:       count = 4'($urandom_range(9, 15));
        2:       count = 4'd2;
        default: count = 4'($urandom_range(3, 8));
      endcase
      // pin the extremes in the first phases
      if (ph == 0) begin
        step  = 16'd0;
        count = 4'd2;
      end else if (ph == 1) begin
        step  = 16'hFFFF;
        count = 4'd15;
      end else if (ph == 2) begin
        count = 4'd0;
      end else if (ph == 3) begin
        count = 4'd8;
      end
      // ascending edges spread over the reachable frequency range, sometimes replaced by random ones
      span = (4095 * int'(step)) >> 8;
      if (span > 65535) span = 65535;
      if (span == 0) span = 1;
      acc = $urandom_range(0, span / 8);
      for (int e = 0; e < 8; e++) begin
        if (acc > 65535) acc = 65535;
        edge_v[e] = 16'(acc);
        acc += $urandom_range(0, span / 4 + 1);
      end
      lo = {edge_v[3], edge_v[2], edge_v[1], edge_v[0]};
      hi = {edge_v[7], edge_v[6], edge_v[5], edge_v[4]};
      if ($urandom_range(0, 3) == 0) begin
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
      end
      load_bands(step, count, lo, hi);

      for (int k = 0; k < PHASE_BEATS; k++) begin
        r = $urandom_range(0, 19);
        if (k == 0 && $urandom_range(0, 1) == 0) op = spbn_pkg::OP_CLEAR;
        else if (r < 8)  op = spbn_pkg::OP_OBSERVE;
        else if (r < 13) op = spbn_pkg::OP_SCALE;
        else if (r < 19) op = spbn_pkg::OP_BAND_SCALE;
        else             op = spbn_pkg::OP_CLEAR;
        case ($urandom_range(0, 7))
          0:       mag = 24'hFFFFFF;
          1:       mag = 24'd0;
          2, 3:    mag = 24'($urandom_range(0, 255));
          default: mag = 24'($urandom);
        endcase
        send_beat(op, 12'($urandom_range(0, 4095)), mag, 1'b0, NO_RES);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("spectrum_band_peak_normalizer: match");
    end else begin
      $display("spectrum_band_peak_normalizer: mismatch");
    end
    $finish;
  end

endmodule
